@@ hw/rtl/mms_pkg.sv @@
package mms_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int ACC_W     = 24;
    localparam int REL_W     = 16;
    localparam int DELTA_W   = 20;
    localparam int TIME_W    = 40;
    localparam int IDLE_W    = 32;
    localparam int OUT_W     = 32;
    localparam int SPS_FRAC  = 8;
    localparam int DQ_W      = DELTA_W + SPS_FRAC;
    localparam int SPS_W     = TIME_W + SPS_FRAC;
    localparam int SCALE_W   = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_DELTA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE     = 2'd2;

    localparam logic [DELTA_W-1:0] MAX_DELTA_RST     = 20'd250000;
    localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST  = 16'd6554;
    localparam logic [TIME_W-1:0]  SAMPLING_TIME_RST = 40'd8000;

    localparam logic CMD_MOTION    = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    typedef enum logic [1:0] {
        DIV_SPS,
        DIV_VAL,
        DIV_CNT,
        DIV_SM
    } div_sel_t;

    typedef enum logic {
        MUL_DQ,
        MUL_SCALE
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_SPS_DIV,
        S_DECIDE,
        S_MUL_START,
        S_DQ_MUL,
        S_VAL_DIV,
        S_CNT_DIV,
        S_SMD_START,
        S_SM_DIV,
        S_SCL_START,
        S_SCL_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     axis;
        logic     motion;
        logic     frame_start;
        logic     load;
        logic     load_sm_val;
        logic     zero_sm;
        logic     zero_idle;
        logic     idle_step;
        logic     store_sm_val;
        logic     store_sm_div;
        logic     store_val_div;
        logic     set_sps;
        logic     set_count;
        logic     store_res;
        logic     commit;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul_start;
        mul_sel_t mul_sel;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic too_long;
        logic val_zero;
        logic sm_zero;
        logic idle_small;
        logic dq_lt;
        logic div_done;
        logic mul_done;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/mms_divider.sv @@
module mms_divider #(
    parameter int NW = 69,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW:0]   quo
);

    localparam int QW  = NW + 1;
    localparam int CNW = $clog2(QW);

    logic [QW-1:0]  sh_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;

    always_comb
    begin
        trial = {rem_reg, sh_reg[QW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {1'b0, num} + QW'(den[DW-1:1]);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[QW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

@@ hw/rtl/mms_multiplier.sv @@
module mms_multiplier #(
    parameter int AW = 41,
    parameter int BW = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int PW  = AW + BW;
    localparam int CNW = $clog2(BW);

    logic [PW-1:0]  a_reg;
    logic [BW-1:0]  b_reg;
    logic [PW-1:0]  prod_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= PW'(a);
            b_reg    <= b;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                prod_reg <= prod_reg + a_reg;
            end
            a_reg <= {a_reg[PW-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ hw/rtl/mms_datapath.sv @@
module mms_datapath #(
    parameter int FRAC_BITS   = mms_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = mms_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mms_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [mms_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [mms_pkg::REL_W-1:0]        rel_x,
    input  logic signed [mms_pkg::REL_W-1:0]        rel_y,
    input  logic [mms_pkg::DELTA_W-1:0]             frame_delta_us,
    input  logic                                    out_stall,
    output logic                                    out_valid,
    output logic signed [mms_pkg::OUT_W-1:0]        axis_x,
    output logic signed [mms_pkg::OUT_W-1:0]        axis_y,
    input  mms_pkg::cmd_t                           cmd,
    output mms_pkg::sts_t                           sts
);

    localparam int ACC_W  = mms_pkg::ACC_W;
    localparam int REL_W  = mms_pkg::REL_W;
    localparam int DEL_W  = mms_pkg::DELTA_W;
    localparam int TIME_W = mms_pkg::TIME_W;
    localparam int IDLE_W = mms_pkg::IDLE_W;
    localparam int OUT_W  = mms_pkg::OUT_W;
    localparam int DQ_W   = mms_pkg::DQ_W;
    localparam int SPS_W  = mms_pkg::SPS_W;
    localparam int SC_W   = mms_pkg::SCALE_W;
    localparam int VW     = 25 + FRAC_BITS;
    localparam int PW     = VW + DQ_W;
    localparam int NW     = PW;
    localparam int DW     = SPS_W;

    logic                   enable_reg;
    logic [DEL_W-1:0]       max_delta_reg;
    logic [SC_W-1:0]        scale_reg;

    logic [ACC_W-1:0]       acc_reg   [2];
    logic [COUNT_WIDTH-1:0] st_reg    [2];
    logic [TIME_W-1:0]      stime_reg [2];
    logic [OUT_W-1:0]       sm_reg    [2];
    logic [IDLE_W-1:0]      idle_reg  [2];
    logic                   frame_seen_reg;

    logic [DEL_W-1:0]       delta_reg;
    logic [VW-1:0]          val_reg;
    logic                   neg_reg;
    logic [SPS_W-1:0]       sps_reg;
    logic [DQ_W-1:0]        count_reg;
    logic [OUT_W-1:0]       res_reg [2];
    logic [OUT_W-1:0]       axis_x_reg;
    logic [OUT_W-1:0]       axis_y_reg;
    logic                   out_valid_reg;

    logic [REL_W-1:0]       rel [2];
    logic [ACC_W-1:0]       acc_mot [2];
    logic [COUNT_WIDTH-1:0] st_mot [2];
    logic [TIME_W-1:0]      stime_mot [2];
    logic                   upd_time [2];

    logic                   k;
    logic [ACC_W-1:0]       acc_k;
    logic [ACC_W-1:0]       acc_abs;
    logic [OUT_W-1:0]       sm_k;
    logic [OUT_W-1:0]       sm_abs;
    logic [DQ_W-1:0]        dq;
    logic [IDLE_W:0]        idle_sum;
    logic [IDLE_W-1:0]      idle_new;
    logic [COUNT_WIDTH-1:0] n_k;
    logic [DW-1:0]          n_den;

    logic [NW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic                   div_done;
    logic [NW:0]            quo;
    logic [DQ_W-1:0]        mul_b;
    logic                   mul_done;
    logic [PW-1:0]          prod;
    logic [PW:0]            rnd_sum;
    logic [VW-1:0]          scaled;
    logic [VW-1:0]          q_v;

    function automatic logic [OUT_W-1:0] sat32(input logic [VW-1:0] mag, input logic neg);
        logic hi;
        if (neg)
        begin
            hi = (|mag[VW-1:OUT_W]) || (mag[OUT_W-1] && (|mag[OUT_W-2:0]));
            sat32 = hi ? {1'b1, {(OUT_W-1){1'b0}}} : (~mag[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            hi = |mag[VW-1:OUT_W-1];
            sat32 = hi ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
        end
    endfunction

    always_comb
    begin
        rel[0] = rel_x;
        rel[1] = rel_y;
        for (int i = 0; i < 2; i++)
        begin
            logic [ACC_W:0]       sum;
            logic [REL_W-1:0]     rabs;
            logic [COUNT_WIDTH:0] ssum;
            logic [TIME_W:0]      tsum;
            sum  = {acc_reg[i][ACC_W-1], acc_reg[i]}
                 + {{(ACC_W + 1 - REL_W){rel[i][REL_W-1]}}, rel[i]};
            if (sum[ACC_W] != sum[ACC_W-1])
            begin
                acc_mot[i] = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                acc_mot[i] = sum[ACC_W-1:0];
            end
            rabs = rel[i][REL_W-1] ? (~rel[i] + 1'b1) : rel[i];
            ssum = {1'b0, st_reg[i]} + (COUNT_WIDTH + 1)'(rabs);
            st_mot[i] = ssum[COUNT_WIDTH] ? '1 : ssum[COUNT_WIDTH-1:0];
            tsum = {1'b0, stime_reg[i]} + (TIME_W + 1)'(frame_delta_us);
            stime_mot[i] = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
            upd_time[i] = !frame_seen_reg && (rel[i] != '0) && (sm_reg[i] != '0);
        end
    end

    always_comb
    begin
        k        = cmd.axis;
        acc_k    = acc_reg[k];
        acc_abs  = acc_k[ACC_W-1] ? (~acc_k + 1'b1) : acc_k;
        sm_k     = sm_reg[k];
        sm_abs   = sm_k[OUT_W-1] ? (~sm_k + 1'b1) : sm_k;
        dq       = {delta_reg, {mms_pkg::SPS_FRAC{1'b0}}};
        idle_sum = {1'b0, idle_reg[k]} + (IDLE_W + 1)'(delta_reg);
        idle_new = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];
        n_k      = st_reg[k];
        n_den    = (n_k == '0) ? DW'(1) : DW'(n_k);

        case (cmd.div_sel)
            mms_pkg::DIV_SPS:
            begin
                div_num = NW'({stime_reg[k], {mms_pkg::SPS_FRAC{1'b0}}});
                div_den = n_den;
            end
            mms_pkg::DIV_VAL:
            begin
                div_num = prod;
                div_den = sps_reg;
            end
            mms_pkg::DIV_CNT:
            begin
                div_num = NW'(dq);
                div_den = sps_reg;
            end
            mms_pkg::DIV_SM:
            begin
                div_num = NW'(val_reg);
                div_den = DW'(count_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = DW'(1);
            end
        endcase

        case (cmd.mul_sel)
            mms_pkg::MUL_DQ:    mul_b = dq;
            mms_pkg::MUL_SCALE: mul_b = DQ_W'(scale_reg);
            default:            mul_b = '0;
        endcase

        rnd_sum = {1'b0, prod} + (PW + 1)'(1 << (SC_W - 1));
        scaled  = rnd_sum[VW+SC_W-1:SC_W];
        q_v     = quo[VW-1:0];

        sts.enable     = enable_reg;
        sts.too_long   = delta_reg >= max_delta_reg;
        sts.val_zero   = val_reg == '0;
        sts.sm_zero    = sm_k == '0;
        sts.idle_small = SPS_W'({idle_new, {mms_pkg::SPS_FRAC{1'b0}}}) < sps_reg;
        sts.dq_lt      = (SPS_W + 1)'(dq) < {sps_reg, 1'b0};
        sts.div_done   = div_done;
        sts.mul_done   = mul_done;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    mms_divider #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    mms_multiplier #(
        .AW (VW),
        .BW (DQ_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (val_reg),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            max_delta_reg  <= mms_pkg::MAX_DELTA_RST;
            scale_reg      <= mms_pkg::OUTPUT_SCALE_RST;
            frame_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                acc_reg[i]   <= '0;
                st_reg[i]    <= COUNT_WIDTH'(1);
                stime_reg[i] <= mms_pkg::SAMPLING_TIME_RST;
                sm_reg[i]    <= '0;
                idle_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mms_pkg::CFG_SMOOTHING_ENABLE: enable_reg    <= cfg_data[0];
                    mms_pkg::CFG_MAX_FRAME_DELTA:  max_delta_reg <= cfg_data;
                    mms_pkg::CFG_OUTPUT_SCALE:     scale_reg     <= cfg_data[SC_W-1:0];
                    default:                       ;
                endcase
            end
            if (cmd.motion)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    acc_reg[i] <= acc_mot[i];
                    st_reg[i]  <= st_mot[i];
                    if (upd_time[i])
                    begin
                        stime_reg[i] <= stime_mot[i];
                    end
                end
                frame_seen_reg <= 1'b1;
            end
            if (cmd.zero_sm)
            begin
                sm_reg[k] <= '0;
            end
            if (cmd.store_sm_val)
            begin
                sm_reg[k] <= sat32(val_reg, neg_reg);
            end
            if (cmd.store_sm_div)
            begin
                sm_reg[k] <= sat32(q_v, neg_reg);
            end
            if (cmd.zero_idle)
            begin
                idle_reg[k] <= '0;
            end
            if (cmd.idle_step)
            begin
                idle_reg[k] <= idle_new;
            end
            if (cmd.commit)
            begin
                acc_reg[0]     <= '0;
                acc_reg[1]     <= '0;
                frame_seen_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_start)
        begin
            delta_reg <= frame_delta_us;
        end
        if (cmd.load)
        begin
            val_reg <= VW'({acc_abs, {FRAC_BITS{1'b0}}});
            neg_reg <= acc_k[ACC_W-1];
        end
        if (cmd.load_sm_val)
        begin
            val_reg <= VW'(sm_abs);
            neg_reg <= sm_k[OUT_W-1];
        end
        if (cmd.store_val_div)
        begin
            val_reg <= q_v;
        end
        if (cmd.set_sps)
        begin
            sps_reg <= (quo[DW-1:0] == '0) ? DW'(1) : quo[DW-1:0];
        end
        if (cmd.set_count)
        begin
            count_reg <= quo[DQ_W-1:0];
        end
        if (cmd.store_res)
        begin
            res_reg[k] <= sat32(scaled, !neg_reg);
        end
        if (cmd.commit)
        begin
            axis_x_reg <= res_reg[0];
            axis_y_reg <= res_reg[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign axis_x    = axis_x_reg;
    assign axis_y    = axis_y_reg;

endmodule

@@ hw/rtl/mms_ctrl.sv @@
module mms_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          command,
    input  mms_pkg::sts_t sts,
    output logic          in_stall,
    output mms_pkg::cmd_t cmd
);

    mms_pkg::state_t state_reg;
    mms_pkg::state_t state_next;
    logic            axis_reg;
    logic            axis_next;
    logic            idle_path_reg;
    logic            idle_path_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mms_pkg::S_IDLE;
            axis_reg      <= 1'b0;
            idle_path_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            idle_path_reg <= idle_path_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        idle_path_next = idle_path_reg;
        cmd            = '0;
        cmd.div_sel    = mms_pkg::DIV_SPS;
        cmd.mul_sel    = mms_pkg::MUL_SCALE;
        cmd.axis       = axis_reg;
        in_stall       = state_reg != mms_pkg::S_IDLE;

        case (state_reg)
            mms_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == mms_pkg::CMD_MOTION)
                    begin
                        cmd.motion = 1'b1;
                    end
                    else
                    begin
                        cmd.frame_start = 1'b1;
                        axis_next       = 1'b0;
                        state_next      = mms_pkg::S_LOAD;
                    end
                end
            end
            mms_pkg::S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = mms_pkg::S_CHECK;
            end
            mms_pkg::S_CHECK:
            begin
                if (!sts.enable)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = mms_pkg::S_SCL_MUL;
                end
                else if (sts.too_long)
                begin
                    cmd.zero_sm   = 1'b1;
                    cmd.zero_idle = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next    = mms_pkg::S_SCL_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = mms_pkg::S_SPS_DIV;
                end
            end
            mms_pkg::S_SPS_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.set_sps = 1'b1;
                    state_next  = mms_pkg::S_DECIDE;
                end
            end
            mms_pkg::S_DECIDE:
            begin
                if (sts.val_zero)
                begin
                    cmd.idle_step = 1'b1;
                    if (sts.idle_small)
                    begin
                        cmd.load_sm_val = 1'b1;
                        idle_path_next  = 1'b1;
                        state_next      = mms_pkg::S_MUL_START;
                    end
                    else
                    begin
                        cmd.zero_sm   = 1'b1;
                        cmd.mul_start = 1'b1;
                        state_next    = mms_pkg::S_SCL_MUL;
                    end
                end
                else
                begin
                    cmd.zero_idle = 1'b1;
                    if (sts.sm_zero)
                    begin
                        cmd.store_sm_val = 1'b1;
                        cmd.mul_start    = 1'b1;
                        state_next       = mms_pkg::S_SCL_MUL;
                    end
                    else if (sts.dq_lt)
                    begin
                        idle_path_next = 1'b0;
                        cmd.mul_sel    = mms_pkg::MUL_DQ;
                        cmd.mul_start  = 1'b1;
                        state_next     = mms_pkg::S_DQ_MUL;
                    end
                    else
                    begin
                        cmd.div_sel   = mms_pkg::DIV_CNT;
                        cmd.div_start = 1'b1;
                        state_next    = mms_pkg::S_CNT_DIV;
                    end
                end
            end
            mms_pkg::S_MUL_START:
            begin
                cmd.mul_sel   = mms_pkg::MUL_DQ;
                cmd.mul_start = 1'b1;
                state_next    = mms_pkg::S_DQ_MUL;
            end
            mms_pkg::S_DQ_MUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.div_sel   = mms_pkg::DIV_VAL;
                    cmd.div_start = 1'b1;
                    state_next    = mms_pkg::S_VAL_DIV;
                end
            end
            mms_pkg::S_VAL_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.store_val_div = 1'b1;
                    cmd.store_sm_div  = !idle_path_reg;
                    state_next        = mms_pkg::S_SCL_START;
                end
            end
            mms_pkg::S_CNT_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.set_count = 1'b1;
                    state_next    = mms_pkg::S_SMD_START;
                end
            end
            mms_pkg::S_SMD_START:
            begin
                cmd.div_sel   = mms_pkg::DIV_SM;
                cmd.div_start = 1'b1;
                state_next    = mms_pkg::S_SM_DIV;
            end
            mms_pkg::S_SM_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.store_sm_div = 1'b1;
                    state_next       = mms_pkg::S_SCL_START;
                end
            end
            mms_pkg::S_SCL_START:
            begin
                cmd.mul_start = 1'b1;
                state_next    = mms_pkg::S_SCL_MUL;
            end
            mms_pkg::S_SCL_MUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.store_res = 1'b1;
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = mms_pkg::S_LOAD;
                    end
                    else
                    begin
                        state_next = mms_pkg::S_OUT;
                    end
                end
            end
            mms_pkg::S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = mms_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mms_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mouse_motion_smoother_core.sv @@
// A motion request is absorbed in the cycle it is accepted. An end-of-frame request
// works on X and then Y with one shared shift-add multiplier (28 steps) and one
// restoring divider that retires one quotient bit per cycle (FRAC_BITS + 54 steps);
// no request is taken while a frame end is being worked on.
// The result stays in an output register, so the next request is accepted while it waits.
module mouse_motion_smoother_core #(
    parameter int FRAC_BITS   = mms_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = mms_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mms_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic signed [mms_pkg::REL_W-1:0]    rel_x,
    input  logic signed [mms_pkg::REL_W-1:0]    rel_y,
    input  logic [mms_pkg::DELTA_W-1:0]         frame_delta_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mms_pkg::OUT_W-1:0]    axis_x,
    output logic signed [mms_pkg::OUT_W-1:0]    axis_y
);

    mms_pkg::cmd_t cmd;
    mms_pkg::sts_t sts;

    mms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    mms_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rel_x          (rel_x),
        .rel_y          (rel_y),
        .frame_delta_us (frame_delta_us),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .axis_x         (axis_x),
        .axis_y         (axis_y),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

@@ dv/mouse_motion_smoother_checker.sv @@
`timescale 1ns / 100ps

module mouse_motion_smoother_checker
    import mms_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        command,
    input  logic signed [REL_W-1:0]     rel_x,
    input  logic signed [REL_W-1:0]     rel_y,
    input  logic [DELTA_W-1:0]          frame_delta_us,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [OUT_W-1:0]     axis_x,
    input  logic signed [OUT_W-1:0]     axis_y,
    output int                          fail_count,
    output int                          pending
);

    localparam logic [63:0] MAG_CAP = 64'd1 << 62;
    localparam longint ACC_HI = 8388607;
    localparam longint ACC_LO = -8388608;
    localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] STIME_MAX = (64'd1 << 40) - 1;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } axis_pair_t;

    axis_pair_t expected_axes[$];

    logic        smooth_on;
    logic [19:0] long_frame_us;
    logic [15:0] gain;

    longint      accum [2];
    logic [63:0] total [2];
    logic [63:0] stime [2];
    longint      smooth_val [2];
    logic [63:0] idle_us [2];
    logic        in_frame;

    assign pending = expected_axes.size();

    function automatic logic [63:0] rounded_ratio(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quot;
        if (d == 0)
            return MAG_CAP;
        prod = 128'(a) * 128'(b) + 128'(d >> 1);
        quot = prod / 128'(d);
        if (quot > 128'(MAG_CAP))
            return MAG_CAP;
        return quot[63:0];
    endfunction

    function automatic longint signed_ratio(longint v, logic [63:0] num, logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r = rounded_ratio(mag, num, den);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint smooth_axis(longint value, int k, logic [63:0] delta);
        logic [63:0] n;
        logic [63:0] sps;
        logic [63:0] dq;
        logic [63:0] count;
        if (delta >= 64'(long_frame_us))
        begin
            smooth_val[k] = 0;
            idle_us[k] = 0;
            return value;
        end
        n = (total[k] != 0) ? total[k] : 64'd1;
        sps = rounded_ratio(stime[k] << SPS_FRAC, 64'd1, n);
        if (sps == 0)
            sps = 1;
        dq = delta << SPS_FRAC;
        if (value == 0)
        begin
            idle_us[k] = idle_us[k] + delta;
            if (idle_us[k] > TOTAL_MAX)
                idle_us[k] = TOTAL_MAX;
            if ((idle_us[k] << SPS_FRAC) < sps)
                value = signed_ratio(smooth_val[k], dq, sps);
            else
                smooth_val[k] = 0;
        end
        else
        begin
            count = 1;
            idle_us[k] = 0;
            if (smooth_val[k] != 0)
            begin
                if (dq < 2 * sps)
                    value = signed_ratio(value, dq, sps);
                else
                    count = rounded_ratio(dq, 64'd1, sps);
            end
            smooth_val[k] = clamp32(signed_ratio(value, 64'd1, count));
        end
        return value;
    endfunction

    task automatic predict_request(logic cmd, longint rx, longint ry, logic [63:0] delta);
        longint rel [2];
        longint a;
        longint value;
        longint res [2];
        axis_pair_t pair;
        rel[0] = rx;
        rel[1] = ry;
        if (cmd == CMD_MOTION)
        begin
            for (int k = 0; k < 2; k++)
            begin
                a = accum[k] + rel[k];
                accum[k] = (a > ACC_HI) ? ACC_HI : ((a < ACC_LO) ? ACC_LO : a);
                total[k] = total[k] + 64'((rel[k] < 0) ? -rel[k] : rel[k]);
                if (total[k] > TOTAL_MAX)
                    total[k] = TOTAL_MAX;
            end
            if (!in_frame)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (rel[k] != 0 && smooth_val[k] != 0)
                    begin
                        stime[k] = stime[k] + delta;
                        if (stime[k] > STIME_MAX)
                            stime[k] = STIME_MAX;
                    end
                end
                in_frame = 1'b1;
            end
        end
        else
        begin
            for (int k = 0; k < 2; k++)
            begin
                value = accum[k] * 65536;
                if (smooth_on)
                    value = smooth_axis(value, k, delta);
                value = signed_ratio(value, 64'(gain), 64'd65536);
                res[k] = clamp32(-value);
                accum[k] = 0;
            end
            in_frame = 1'b0;
            pair.x = res[0][31:0];
            pair.y = res[1][31:0];
            expected_axes = {expected_axes, pair};
        end
    endtask

    task automatic note_mismatch(string what, logic signed [31:0] want,
                                 logic signed [31:0] got);
        if (fail_count < 10)
            $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        axis_pair_t head;
        if (!rst_n)
        begin
            smooth_on = 1'b0;
            long_frame_us = MAX_DELTA_RST;
            gain = OUTPUT_SCALE_RST;
            for (int k = 0; k < 2; k++)
            begin
                accum[k] = 0;
                total[k] = 1;
                stime[k] = 64'(SAMPLING_TIME_RST);
                smooth_val[k] = 0;
                idle_us[k] = 0;
            end
            in_frame = 1'b0;
            expected_axes.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SMOOTHING_ENABLE: smooth_on = cfg_data[0];
                    CFG_MAX_FRAME_DELTA:  long_frame_us = cfg_data;
                    CFG_OUTPUT_SCALE:     gain = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_axes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result at %0t: x %0d y %0d", $realtime,
                                 axis_x, axis_y);
                    fail_count++;
                end
                else
                begin
                    head = expected_axes.pop_front();
                    if (axis_x !== head.x)
                        note_mismatch("axis_x", head.x, axis_x);
                    if (axis_y !== head.y)
                        note_mismatch("axis_y", head.y, axis_y);
                end
            end
            if (in_valid && !in_stall)
                predict_request(command, longint'(rel_x), longint'(rel_y),
                                64'(frame_delta_us));
        end
    end

endmodule

@@ dv/mouse_motion_smoother_core_tb.sv @@
`timescale 1ns / 100ps

module mouse_motion_smoother_core_tb;
    import mms_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_GOAL = 1850;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    command;
    logic signed [REL_W-1:0] rel_x;
    logic signed [REL_W-1:0] rel_y;
    logic [DELTA_W-1:0]      frame_delta_us;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] axis_x;
    logic signed [OUT_W-1:0] axis_y;
    int                      fail_count;
    int                      pending;

    int          cycles;
    int          sent;
    int          frames;
    int          hold_asked;
    int          hold_done;
    logic        calm;
    logic [19:0] long_frame_us;

    mouse_motion_smoother_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .rel_x(rel_x), .rel_y(rel_y), .frame_delta_us(frame_delta_us),
        .out_valid(out_valid), .out_stall(out_stall), .axis_x(axis_x), .axis_y(axis_y)
    );

    mouse_motion_smoother_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .rel_x(rel_x), .rel_y(rel_y), .frame_delta_us(frame_delta_us),
        .out_valid(out_valid), .out_stall(out_stall), .axis_x(axis_x), .axis_y(axis_y),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycles);
            $display("mouse_motion_smoother_core verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    initial
    begin
        int run;
        out_stall <= 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_asked != hold_done)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_done = hold_asked;
            end
            out_stall <= 1'b0;
            @(posedge clk);
            run = pick_gap();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    task automatic send_request(logic cmd, logic [15:0] rx, logic [15:0] ry,
                                logic [19:0] delta);
        logic taken;
        int gap;
        command <= cmd;
        rel_x <= rx;
        rel_y <= ry;
        frame_delta_us <= delta;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        sent++;
        if (cmd == CMD_FRAME_END)
            frames++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic configure(logic en, logic [19:0] max_us, logic [15:0] scale);
        wait_quiet();
        write_reg(CFG_SMOOTHING_ENABLE, 20'(en));
        write_reg(CFG_MAX_FRAME_DELTA, max_us);
        write_reg(CFG_OUTPUT_SCALE, 20'(scale));
        cfg_we <= 1'b0;
        long_frame_us = max_us;
    endtask

    function automatic logic [15:0] pick_rel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 16'($signed($urandom_range(0, 100)) - 50);
        if (r < 80)
            return 16'($urandom);
        if (r < 93)
            return 16'd0;
        return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endfunction

    function automatic logic [19:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 20'($urandom_range(500, 20000));
        if (r < 87)
            return 20'($urandom_range(0, 10));
        if (r < 94)
            return long_frame_us + 20'($signed($urandom_range(0, 2)) - 1);
        return 20'($urandom);
    endfunction

    task automatic send_frame();
        int n;
        logic [19:0] delta;
        logic [15:0] big;
        delta = pick_delta();
        if ($urandom_range(0, 99) < 2)
        begin
            big = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            repeat (260) send_request(CMD_MOTION, big, ~big, delta);
        end
        else
        begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            repeat (n) send_request(CMD_MOTION, pick_rel(), pick_rel(), delta);
        end
        send_request(CMD_FRAME_END, pick_rel(), pick_rel(), delta);
    endtask

    task automatic random_phase(int count);
        int goal;
        goal = sent + count;
        while (sent < goal)
            send_frame();
    endtask

    initial
    begin
        sent = 0;
        frames = 0;
        hold_asked = 0;
        calm = 1'b0;
        long_frame_us = MAX_DELTA_RST;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SMOOTHING_ENABLE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        command <= CMD_MOTION;
        rel_x <= '0;
        rel_y <= '0;
        frame_delta_us <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_phase(200);

        configure(1'b1, MAX_DELTA_RST, OUTPUT_SCALE_RST);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd8000);
        send_request(CMD_MOTION, 16'h7FFF, 16'h8000, 20'd8000);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd8000);
        send_request(CMD_MOTION, 16'd5, 16'hFFFB, 20'd8000);
        send_request(CMD_MOTION, 16'd3, 16'd0, 20'd8000);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd8000);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd1);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd40000);
        send_request(CMD_MOTION, 16'd7, 16'd7, 20'd0);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd0);
        send_request(CMD_MOTION, 16'd9, 16'hFFF7, 20'd30000);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd30000);
        send_request(CMD_MOTION, 16'd1, 16'd1, 20'd249999);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd249999);
        send_request(CMD_MOTION, 16'd2, 16'd2, 20'd250000);
        send_request(CMD_FRAME_END, 16'd0, 16'd0, 20'd250000);
        send_request(CMD_MOTION, 16'd4, 16'hFFFC, 20'hFFFFF);
        send_request(CMD_FRAME_END, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        random_phase(250);

        configure(1'b1, 20'd1, 16'hFFFF);
        calm = 1'b1;
        random_phase(200);
        calm = 1'b0;

        configure(1'b1, 20'd1000000, 16'd0);
        random_phase(200);

        configure(1'b0, 20'd5000, 16'hFFFF);
        random_phase(200);

        configure(1'b1, 20'd30000, 16'd40000);
        random_phase(300);

        configure(1'b1, 20'd1000000, OUTPUT_SCALE_RST);
        hold_asked++;
        repeat (30) send_frame();
        wait_quiet();
        while (sent < ITEM_GOAL)
            send_frame();

        wait_quiet();
        $display("Sent %0d requests, %0d of them frame ends, over seven register settings.",
                 sent, frames);
        $display("Smoothing on and off, long-frame limits 1 to 1000000, gains 0 to 65535.");
        if (fail_count == 0 && pending == 0)
            $display("mouse_motion_smoother_core verification clean");
        else
            $display("mouse_motion_smoother_core verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mms_pkg.sv
hw/rtl/mms_divider.sv
hw/rtl/mms_multiplier.sv
hw/rtl/mms_datapath.sv
hw/rtl/mms_ctrl.sv
hw/rtl/mouse_motion_smoother_core.sv
dv/mouse_motion_smoother_checker.sv
dv/mouse_motion_smoother_core_tb.sv
